// ===== hdl/smbu_pkg.sv =====
// Package for the bounded uniform generator: constants, state encoding and
// the status word shared between the arithmetic units and the sequencer.
// No dependencies.
`default_nettype none

package smbu_pkg;

  localparam int unsigned BoundW = 32;
  localparam int unsigned WordW  = 64;

  localparam logic [WordW-1:0] Gamma = 64'h9e3779b97f4a7c15;
  localparam logic [WordW-1:0] Mul1  = 64'hbf58476d1ce4e5b9;
  localparam logic [WordW-1:0] Mul2  = 64'h94d049bb133111eb;

  localparam int unsigned Shift1 = 30;
  localparam int unsigned Shift2 = 27;
  localparam int unsigned Shift3 = 31;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_THR_GO,
    S_THR_WAIT,
    S_ADV,
    S_MUL1_GO,
    S_MUL1_WAIT,
    S_MUL2_GO,
    S_MUL2_WAIT,
    S_CHECK,
    S_MOD_GO,
    S_MOD_WAIT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/smbu_if.sv =====
// Valid/ready channel interfaces for the request (bound) and response (value).
// Depends on smbu_pkg for field widths.
`default_nettype none

interface smbu_req_if;
  logic                          valid;
  logic                          ready;
  logic [smbu_pkg::BoundW-1:0]   limit;

  modport source (output valid, output limit, input ready);
  modport sink (input valid, input limit, output ready);
endinterface

interface smbu_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [smbu_pkg::BoundW-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== hdl/smbu_mul.sv =====
// Iterative 64x64 multiplier keeping the low 64 bits, built on one 32x32
// multiplier over three partial products. Depends on smbu_pkg.
`default_nettype none

module smbu_mul (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [smbu_pkg::WordW-1:0]  a,
  input  wire logic [smbu_pkg::WordW-1:0]  b,
  output smbu_pkg::unit_sts_t              sts,
  output logic      [smbu_pkg::WordW-1:0]  product
);

  logic [smbu_pkg::WordW-1:0]  opa;
  logic [smbu_pkg::WordW-1:0]  opb;
  logic [smbu_pkg::WordW-1:0]  prod;
  logic [smbu_pkg::WordW-1:0]  acc;
  logic [1:0]                  step;
  logic                        busy;
  logic                        done;
  logic [31:0]                 mul_a;
  logic [31:0]                 mul_b;

  always_comb begin
    case (step)
      2'd0:    begin mul_a = opa[31:0];  mul_b = opb[31:0];  end
      2'd1:    begin mul_a = opa[31:0];  mul_b = opb[63:32]; end
      default: begin mul_a = opa[63:32]; mul_b = opb[31:0];  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opa <= a;
      opb <= b;
    end
    if (busy) begin
      prod <= mul_a * mul_b;
      case (step)
        2'd1:    acc <= prod;
        2'd0:    acc <= acc;
        default: acc <= acc + {prod[31:0], 32'd0};
      endcase
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign product  = acc;

endmodule

`default_nettype wire

// ===== hdl/smbu_div.sv =====
// Restoring radix-2 remainder unit: 64-bit dividend by 32-bit divisor,
// one quotient bit per cycle. Depends on smbu_pkg.
`default_nettype none

module smbu_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [smbu_pkg::WordW-1:0]   dividend,
  input  wire logic [smbu_pkg::BoundW-1:0]  divisor,
  output smbu_pkg::unit_sts_t               sts,
  output logic      [smbu_pkg::BoundW-1:0]  remainder
);

  logic [smbu_pkg::WordW-1:0]   dvd;
  logic [smbu_pkg::BoundW-1:0]  dsr;
  logic [smbu_pkg::BoundW-1:0]  rem;
  logic [5:0]                   cnt;
  logic                         busy;
  logic                         done;
  logic [smbu_pkg::BoundW:0]    trial;

  assign trial = {rem, dvd[smbu_pkg::WordW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[smbu_pkg::WordW-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem <= smbu_pkg::BoundW'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[smbu_pkg::BoundW-1:0];
      end
    end
  end

  assign sts.busy  = busy;
  assign sts.done  = done;
  assign remainder = rem;

endmodule

`default_nettype wire

// ===== hdl/splitmix64_bounded_uniform.sv =====
// Top level of the SplitMix64 bounded uniform generator: sequencer, counter
// and output register. Depends on smbu_pkg, smbu_if, smbu_mul and smbu_div.
//
// Each request word carries a bound; the response word is an unbiased value
// in 0..bound-1 (0 for a zero bound, which leaves the counter untouched).
// One request is in flight at a time and req.ready is low while it is worked
// on. A nonzero bound first takes the threshold remainder, then draws (counter
// step, two passes through the shared 32x32 multiplier and the compare) until
// a draw is accepted, and then takes the final remainder.
// Both remainders run on one bit-serial divider at one bit per cycle.
// Writing wr_data with wr_en high loads the counter; write only while idle.
`default_nettype none

module splitmix64_bounded_uniform (
  input  wire logic                         clk,
  input  wire logic                         rst,
  smbu_req_if.sink                          req,
  smbu_rsp_if.source                        rsp,
  input  wire logic                         wr_en,
  input  wire logic [smbu_pkg::WordW-1:0]   wr_data
);

  smbu_pkg::state_t             state;
  smbu_pkg::state_t             state_next;
  logic [smbu_pkg::WordW-1:0]   counter;
  logic [smbu_pkg::WordW-1:0]   x;
  logic [smbu_pkg::BoundW-1:0]  bound;
  logic [smbu_pkg::BoundW-1:0]  thresh;
  logic [smbu_pkg::BoundW-1:0]  res;
  logic                         rsp_valid;
  logic [smbu_pkg::BoundW-1:0]  rsp_value;

  logic                         mul_start;
  logic [smbu_pkg::WordW-1:0]   mul_b;
  logic [smbu_pkg::WordW-1:0]   mul_p;
  smbu_pkg::unit_sts_t          mul_sts;
  logic                         div_start;
  logic [smbu_pkg::WordW-1:0]   div_dvd;
  logic [smbu_pkg::BoundW-1:0]  div_rem;
  smbu_pkg::unit_sts_t          div_sts;

  logic                         accept;
  logic                         out_load;
  logic [smbu_pkg::WordW-1:0]   ctr_step;

  assign accept   = req.valid && req.ready;
  assign out_load = (state == smbu_pkg::S_DONE) && (!rsp_valid || rsp.ready);
  assign ctr_step = counter + smbu_pkg::Gamma;

  smbu_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (x),
    .b       (mul_b),
    .sts     (mul_sts),
    .product (mul_p)
  );

  smbu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (bound),
    .sts       (div_sts),
    .remainder (div_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      smbu_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (req.limit == '0) ? smbu_pkg::S_DONE : smbu_pkg::S_THR_GO;
        end
      end
      smbu_pkg::S_THR_GO:    state_next = smbu_pkg::S_THR_WAIT;
      smbu_pkg::S_THR_WAIT: begin
        if (div_sts.done) state_next = smbu_pkg::S_ADV;
      end
      smbu_pkg::S_ADV:       state_next = smbu_pkg::S_MUL1_GO;
      smbu_pkg::S_MUL1_GO:   state_next = smbu_pkg::S_MUL1_WAIT;
      smbu_pkg::S_MUL1_WAIT: begin
        if (mul_sts.done) state_next = smbu_pkg::S_MUL2_GO;
      end
      smbu_pkg::S_MUL2_GO:   state_next = smbu_pkg::S_MUL2_WAIT;
      smbu_pkg::S_MUL2_WAIT: begin
        if (mul_sts.done) state_next = smbu_pkg::S_CHECK;
      end
      smbu_pkg::S_CHECK: begin
        state_next = (x < {32'd0, thresh}) ? smbu_pkg::S_ADV : smbu_pkg::S_MOD_GO;
      end
      smbu_pkg::S_MOD_GO:    state_next = smbu_pkg::S_MOD_WAIT;
      smbu_pkg::S_MOD_WAIT: begin
        if (div_sts.done) state_next = smbu_pkg::S_DONE;
      end
      smbu_pkg::S_DONE: begin
        if (out_load) state_next = smbu_pkg::S_IDLE;
      end
      default:               state_next = smbu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == smbu_pkg::S_IDLE);
    mul_start = (state == smbu_pkg::S_MUL1_GO) || (state == smbu_pkg::S_MUL2_GO);
    mul_b     = (state == smbu_pkg::S_MUL1_GO) ? smbu_pkg::Mul1 : smbu_pkg::Mul2;
    div_start = (state == smbu_pkg::S_THR_GO) || (state == smbu_pkg::S_MOD_GO);
    div_dvd   = (state == smbu_pkg::S_THR_GO) ? (64'd0 - {32'd0, bound}) : x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= smbu_pkg::S_IDLE;
      counter   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        counter <= wr_data;
      end else if (state == smbu_pkg::S_ADV) begin
        counter <= ctr_step;
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bound <= req.limit;
      res   <= '0;
    end
    if (state == smbu_pkg::S_THR_WAIT && div_sts.done) thresh <= div_rem;
    if (state == smbu_pkg::S_MOD_WAIT && div_sts.done) res <= div_rem;
    if (state == smbu_pkg::S_ADV) x <= ctr_step ^ (ctr_step >> smbu_pkg::Shift1);
    if (state == smbu_pkg::S_MUL1_WAIT && mul_sts.done) begin
      x <= mul_p ^ (mul_p >> smbu_pkg::Shift2);
    end
    if (state == smbu_pkg::S_MUL2_WAIT && mul_sts.done) begin
      x <= mul_p ^ (mul_p >> smbu_pkg::Shift3);
    end
    if (out_load) rsp_value <= res;
  end

  assign rsp.valid = rsp_valid;
  assign rsp.value = rsp_value;

  ap_units_idle_when_ready: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> (!mul_sts.busy && !div_sts.busy))
    else $error("arithmetic unit busy while accepting a request");

  ap_zero_bound_direct: assert property (@(posedge clk) disable iff (rst)
    (accept && req.limit == '0) |=> (state == smbu_pkg::S_DONE && res == '0))
    else $error("zero bound did not go straight to the response");

  ap_result_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == smbu_pkg::S_MOD_WAIT && div_sts.done) |=> (res < bound))
    else $error("result not below bound");

  ap_counter_holds: assert property (@(posedge clk) disable iff (rst)
    (state != smbu_pkg::S_ADV && !wr_en) |=> $stable(counter))
    else $error("counter moved outside a draw");

endmodule

`default_nettype wire
